FILE: design/irsw_pkg.sv
// Shared types and constants for the in-order retire send window.
// No dependencies; every other design file refers to this package.
package irsw_pkg;

  localparam int RING_DEPTH = 64;
  localparam int SLOT_W = $clog2(RING_DEPTH);
  localparam int SEQ_W = 32;
  localparam int CNT_W = 5;
  localparam logic [CNT_W-1:0] MAX_SENDS = CNT_W'(16);
  localparam logic [SEQ_W-1:0] WIN_LIMIT = SEQ_W'(RING_DEPTH - 1);

  typedef enum logic [1:0] {
    OP_ADD    = 2'd0,
    OP_DONE   = 2'd1,
    OP_TICK   = 2'd2,
    OP_CANCEL = 2'd3
  } op_t;

  localparam logic [1:0] CFG_CONC     = 2'd0;
  localparam logic [1:0] CFG_WRITERS  = 2'd1;
  localparam logic [1:0] CFG_RESERVE  = 2'd2;

  typedef struct packed {
    op_t              op;
    logic [SEQ_W-1:0] req_tag;
    logic             req_eos;
    logic             req_has_chunks;
    logic [SEQ_W-1:0] done_seq;
    logic             done_ok;
  } item_t;

  typedef struct packed {
    logic  valid;
    item_t item;
  } head_t;

endpackage

FILE: design/inorder_retire_send_window_top.sv
// Top level of the in-order retire send window.
// Depends on irsw_pkg, irsw_front and irsw_back.
//
// Usage:
//   Requests enter on start/busy: one is taken at each clock edge with start
//   high and busy low. The front queue holds two requests, so busy rises only
//   when two are waiting behind the one in progress.
//   Each request produces zero or more send results (kind = 1, a tick only)
//   followed by exactly one status result with last = 1. Every result is on
//   the result ports for one cycle under strobe; the receiver cannot stall.
//   Add and cancel go straight to S_STATUS, a completion through S_CMPL first.
//   A tick retires R entries one a cycle in S_RETIRE; each of S sends then
//   passes S_SEND_RD, which reads the single ring read port, and S_SEND. It
//   leaves from S_SEND_RD with nothing left to send, or from S_SEND on a
//   refused send. Registers are written on cfg_valid/cfg_ready (always ready);
//   the user must write them only while idle, as the block does not enforce it.
//   Reset (rst, synchronous) clears the window to empty with all sequence
//   counters at all ones and loads the register defaults.
module inorder_retire_send_window_top (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  op,
  input  logic [31:0] req_tag,
  input  logic        req_eos,
  input  logic        req_has_chunks,
  input  logic [31:0] done_seq,
  input  logic        done_ok,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [5:0]  cfg_data,
  output logic        strobe,
  output logic        kind,
  output logic [31:0] sent_seq,
  output logic [31:0] sent_tag,
  output logic        sent_eos,
  output logic        is_full,
  output logic        finished,
  output logic        rpc_error,
  output logic        overflow,
  output logic        last
);

  irsw_pkg::head_t head;
  logic            pop;

  irsw_front u_front (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .op(op), .req_tag(req_tag),
    .req_eos(req_eos), .req_has_chunks(req_has_chunks), .done_seq(done_seq),
    .done_ok(done_ok), .head(head), .pop(pop)
  );

  irsw_back u_back (
    .clk(clk), .rst(rst), .head(head), .pop(pop), .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .strobe(strobe), .kind(kind), .sent_seq(sent_seq), .sent_tag(sent_tag),
    .sent_eos(sent_eos), .is_full(is_full), .finished(finished),
    .rpc_error(rpc_error), .overflow(overflow), .last(last)
  );

endmodule

FILE: design/irsw_front.sv
// Front end: accepts requests and holds them in a two-entry queue.
// Depends on irsw_pkg.
module irsw_front (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  output logic                        busy,
  input  logic [1:0]                  op,
  input  logic [irsw_pkg::SEQ_W-1:0]  req_tag,
  input  logic                        req_eos,
  input  logic                        req_has_chunks,
  input  logic [irsw_pkg::SEQ_W-1:0]  done_seq,
  input  logic                        done_ok,
  output irsw_pkg::head_t             head,
  input  logic                        pop
);

  irsw_pkg::item_t q [2];
  logic       wp;
  logic       rp;
  logic [1:0] cnt;
  logic [1:0] cnt_next;
  logic       push;

  assign busy = (cnt == 2'd2);
  assign push = start && !busy;

  always_comb begin
    unique case ({push, pop})
      2'b10:   cnt_next = cnt + 2'd1;
      2'b01:   cnt_next = cnt - 2'd1;
      default: cnt_next = cnt;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= 2'd0;
      wp  <= 1'b0;
      rp  <= 1'b0;
    end else begin
      cnt <= cnt_next;
      if (push) wp <= ~wp;
      if (pop) rp <= ~rp;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q[wp].op             <= irsw_pkg::op_t'(op);
      q[wp].req_tag        <= req_tag;
      q[wp].req_eos        <= req_eos;
      q[wp].req_has_chunks <= req_has_chunks;
      q[wp].done_seq       <= done_seq;
      q[wp].done_ok        <= done_ok;
    end
  end

  assign head.valid = (cnt != 2'd0);
  assign head.item  = q[rp];

endmodule

FILE: design/irsw_back.sv
// Back end: window state, ring memory, retire and send sequencer, results.
// Depends on irsw_pkg; fed by irsw_front.
module irsw_back (
  input  logic                        clk,
  input  logic                        rst,
  input  irsw_pkg::head_t             head,
  output logic                        pop,
  input  logic                        cfg_valid,
  output logic                        cfg_ready,
  input  logic [1:0]                  cfg_index,
  input  logic [5:0]                  cfg_data,
  output logic                        strobe,
  output logic                        kind,
  output logic [irsw_pkg::SEQ_W-1:0]  sent_seq,
  output logic [irsw_pkg::SEQ_W-1:0]  sent_tag,
  output logic                        sent_eos,
  output logic                        is_full,
  output logic                        finished,
  output logic                        rpc_error,
  output logic                        overflow,
  output logic                        last
);

  typedef enum logic [5:0] {
    S_IDLE    = 6'b000001,
    S_CMPL    = 6'b000010,
    S_RETIRE  = 6'b000100,
    S_SEND_RD = 6'b001000,
    S_SEND    = 6'b010000,
    S_STATUS  = 6'b100000
  } state_t;

  localparam int SW = irsw_pkg::SLOT_W;
  localparam int QW = irsw_pkg::SEQ_W;
  localparam int CW = irsw_pkg::CNT_W;

  state_t state;
  logic [CW-1:0] conc_lim;
  logic [CW-1:0] writers;
  logic [5:0]    reserve;
  logic [QW-1:0] arrived;
  logic [QW-1:0] sent;
  logic [QW-1:0] acked;
  logic          any_acked;
  logic [CW-1:0] inflight;
  logic [CW-1:0] eos_left;
  logic [CW-1:0] sinkers;
  logic          finishing;
  logic [irsw_pkg::RING_DEPTH-1:0] ready_f;
  logic [irsw_pkg::RING_DEPTH-1:0] done_f;
  logic          err_f;
  logic          ovf_f;
  logic          cmp_hit;
  logic          cmp_ok;
  logic [SW-1:0] cmp_slot;

  logic [QW:0]   ring [irsw_pkg::RING_DEPTH];
  logic [QW:0]   rd_data;
  logic [SW-1:0] rd_addr;
  logic          wr_en;

  irsw_pkg::item_t it;
  logic [CW-1:0] new_left;
  logic [CW-1:0] sink_dec;
  logic          store;
  logic          st_eos;
  logic          full_win;
  logic [QW-1:0] off;
  logic [QW-1:0] span;
  logic          hit;
  logic [CW-1:0] lim;
  logic [QW-1:0] next_sent;
  logic [QW-1:0] ack_next_w;
  logic [SW-1:0] ack_slot_w;
  logic [QW-1:0] arr_next;
  logic [SW-1:0] wr_slot;
  logic          send_ok;
  logic          emit_send;
  logic          full_now;

  assign it        = head.item;
  assign pop       = (state == S_IDLE) && head.valid;
  assign cfg_ready = 1'b1;

  assign sink_dec = (sinkers != '0) ? sinkers - CW'(1) : '0;
  always_comb begin
    new_left = eos_left;
    if (it.req_eos) new_left = (eos_left != '0) ? eos_left - CW'(1) : '0;
  end
  assign store    = !(it.req_eos && new_left != '0 && !it.req_has_chunks);
  assign st_eos   = it.req_eos && new_left == '0;
  assign full_win = (arrived - acked) >= irsw_pkg::WIN_LIMIT;
  assign off      = it.done_seq - acked - QW'(1);
  assign span     = sent - acked;
  assign hit      = (off < span) && !done_f[it.done_seq[SW-1:0]];
  assign lim      = (conc_lim > irsw_pkg::MAX_SENDS) ? irsw_pkg::MAX_SENDS : conc_lim;
  assign next_sent = sent + QW'(1);
  assign ack_next_w = acked + QW'(1);
  assign ack_slot_w = ack_next_w[SW-1:0];
  assign arr_next = arrived + QW'(1);
  assign wr_slot  = arr_next[SW-1:0];

  assign send_ok = !(finishing || inflight >= lim || !ready_f[next_sent[SW-1:0]] ||
                     (!any_acked && inflight != '0) || (rd_data[QW] && inflight != '0));
  assign emit_send = (state == S_SEND) && send_ok;
  assign full_now  = ({1'b0, arrived - sent} + (QW+1)'(writers)) > (QW+1)'(reserve);

  assign wr_en   = pop && it.op == irsw_pkg::OP_ADD && !finishing && store && !full_win;
  assign rd_addr = (state == S_SEND_RD) ? next_sent[SW-1:0] : it.done_seq[SW-1:0];

  always_ff @(posedge clk) begin
    if (wr_en) ring[wr_slot] <= {st_eos, it.req_tag};
    rd_data <= ring[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      conc_lim  <= CW'(8);
      writers   <= CW'(1);
      reserve   <= 6'd8;
      arrived   <= '1;
      sent      <= '1;
      acked     <= '1;
      any_acked <= 1'b0;
      inflight  <= '0;
      eos_left  <= CW'(1);
      sinkers   <= CW'(1);
      finishing <= 1'b0;
      ready_f   <= '0;
      done_f    <= '0;
      err_f     <= 1'b0;
      ovf_f     <= 1'b0;
      cmp_hit   <= 1'b0;
      cmp_ok    <= 1'b0;
      cmp_slot  <= '0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        unique case (cfg_index)
          irsw_pkg::CFG_CONC: conc_lim <= cfg_data[CW-1:0];
          irsw_pkg::CFG_WRITERS: begin
            writers  <= cfg_data[CW-1:0];
            eos_left <= cfg_data[CW-1:0];
            sinkers  <= cfg_data[CW-1:0];
          end
          irsw_pkg::CFG_RESERVE: reserve <= cfg_data;
          default: ;
        endcase
      end
      unique case (state)
        S_IDLE: begin
          if (head.valid) begin
            err_f <= 1'b0;
            ovf_f <= 1'b0;
            unique case (it.op)
              irsw_pkg::OP_ADD: begin
                if (!finishing) begin
                  if (store && full_win) begin
                    ovf_f <= 1'b1;
                  end else begin
                    eos_left <= new_left;
                    if (store) begin
                      arrived          <= arr_next;
                      ready_f[wr_slot] <= 1'b1;
                    end
                  end
                end
                state <= S_STATUS;
              end
              irsw_pkg::OP_DONE: begin
                cmp_hit  <= hit;
                cmp_ok   <= it.done_ok;
                cmp_slot <= it.done_seq[SW-1:0];
                state    <= S_CMPL;
              end
              irsw_pkg::OP_TICK: state <= S_RETIRE;
              irsw_pkg::OP_CANCEL: begin
                sinkers <= sink_dec;
                if (sink_dec == '0) finishing <= 1'b1;
                state <= S_STATUS;
              end
              default: state <= S_STATUS;
            endcase
          end
        end
        S_CMPL: begin
          if (cmp_hit) begin
            if (inflight != '0) inflight <= inflight - CW'(1);
            if (!cmp_ok) begin
              finishing <= 1'b1;
              err_f     <= 1'b1;
            end else begin
              done_f[cmp_slot] <= 1'b1;
              if (rd_data[QW]) finishing <= 1'b1;
            end
          end
          state <= S_STATUS;
        end
        S_RETIRE: begin
          if (sent != acked && done_f[ack_slot_w]) begin
            done_f[ack_slot_w] <= 1'b0;
            acked              <= ack_next_w;
            any_acked          <= 1'b1;
          end else begin
            state <= S_SEND_RD;
          end
        end
        S_SEND_RD: state <= (sent == arrived) ? S_STATUS : S_SEND;
        S_SEND: begin
          if (send_ok) begin
            inflight                     <= inflight + CW'(1);
            ready_f[next_sent[SW-1:0]]   <= 1'b0;
            sent                         <= next_sent;
            state                        <= S_SEND_RD;
          end else begin
            state <= S_STATUS;
          end
        end
        S_STATUS: state <= S_IDLE;
        default:  state <= S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) strobe <= 1'b0;
    else     strobe <= emit_send || (state == S_STATUS);
  end

  always_ff @(posedge clk) begin
    if (emit_send) begin
      kind        <= 1'b1;
      sent_seq    <= next_sent;
      sent_tag    <= rd_data[QW-1:0];
      sent_eos    <= rd_data[QW];
      is_full     <= 1'b0;
      finished    <= 1'b0;
      rpc_error   <= 1'b0;
      overflow    <= 1'b0;
      last        <= 1'b0;
    end else begin
      kind        <= 1'b0;
      sent_seq    <= '0;
      sent_tag    <= '0;
      sent_eos    <= 1'b0;
      is_full     <= full_now;
      finished    <= finishing && inflight == '0;
      rpc_error   <= err_f;
      overflow    <= ovf_f;
      last        <= 1'b1;
    end
  end

  a_inflight_cap: assert property (@(posedge clk) disable iff (rst)
    inflight <= irsw_pkg::MAX_SENDS) else $error("in-flight count above cap");
  a_window: assert property (@(posedge clk) disable iff (rst)
    (arrived - acked) < QW'(irsw_pkg::RING_DEPTH)) else $error("window overrun");
  a_status_out: assert property (@(posedge clk) disable iff (rst)
    state == S_STATUS |=> strobe && last && !kind) else $error("status result missing");
  a_send_not_last: assert property (@(posedge clk) disable iff (rst)
    strobe && kind |-> !last) else $error("send result marked last");

endmodule
